// File: sv/fts_pkg.sv
// ---------------------------------------------------------------------------
// Function table and call stack package
// Shared types, codes and default sizes for the function table call stack.
// ---------------------------------------------------------------------------
package fts_pkg;

    // Default sizes of the stores
    localparam int TABLE_DEPTH_DEFAULT = 32;
    localparam int STACK_DEPTH_DEFAULT = 64;
    localparam int KEY_WIDTH_DEFAULT   = 32;

    // Field widths
    localparam int POS_W   = 24;
    localparam int ID_W    = 32;
    localparam int DEPTH_W = 7;

    // Reset value of the depth limit register
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RESET = 7'd64;

    // Command kinds
    typedef enum logic [1:0] {
        KIND_DEFINE = 2'd0,
        KIND_CALL   = 2'd1,
        KIND_RETURN = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EXISTS = 3'd1,
        ST_UNDEF  = 3'd2,
        ST_DEPTH  = 3'd3,
        ST_EMPTY  = 3'd4,
        ST_TFULL  = 3'd5
    } status_t;

    // One command transfer
    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  func_id;
        logic [POS_W-1:0] code_position;
    } cmd_t;

    // One result transfer
    typedef struct packed {
        logic [POS_W-1:0]   new_position;
        logic [2:0]         status;
        logic [DEPTH_W-1:0] call_depth;
    } result_t;

endpackage

// File: sv/fts_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module fts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/function_table_call_stack_unit.sv
// ---------------------------------------------------------------------------
// Function table call stack unit
// Function table and return stack of a small interpreter, held in two RAMs.
// ---------------------------------------------------------------------------
// Usage:
//   A command transfer takes place at a rising edge with start high and busy
//   low. Each command gives one result, shown on result for one cycle with
//   done high; the receiver cannot hold it off, so it must take it then.
//   cfg_we writes cfg_data to the depth limit register; write only when idle.
// Timing:
//   Define and call scan the table RAM one entry a cycle through its registered
//   read, stopping at a hit. An empty table skips the scan. Return reads the
//   stack RAM once; an unused kind or a return on an empty stack finishes
//   without leaving idle. The result strobe comes in the cycle after the
//   decision, when busy has fallen again.
// Reset:
//   Reset empties the table (fill count zero) and the stack, sets the depth
//   limit to 64 and drops any command under way. No clearing pass is needed.
// ---------------------------------------------------------------------------
module function_table_call_stack_unit #(
    parameter int TABLE_DEPTH = fts_pkg::TABLE_DEPTH_DEFAULT,
    parameter int STACK_DEPTH = fts_pkg::STACK_DEPTH_DEFAULT,
    parameter int KEY_WIDTH   = fts_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  fts_pkg::cmd_t                 cmd,
    output logic                          done,
    output fts_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [fts_pkg::DEPTH_W-1:0]   cfg_data
);

    localparam int TAW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW   = $clog2(TABLE_DEPTH + 1);
    localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int AC   = $clog2(STACK_DEPTH + 1);
    localparam int POSW = fts_pkg::POS_W;
    localparam int TW   = KEY_WIDTH + POSW;
    localparam int DW   = fts_pkg::DEPTH_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_POP    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Control state
    logic [FW-1:0]              fill_reg, fill_next;
    logic [AC-1:0]              active_reg, active_next;
    logic [fts_pkg::DEPTH_W-1:0] limit_reg;
    logic [TAW-1:0]             idx_reg, idx_next;
    logic                       issued_all_reg, issued_all_next;
    logic                       rvalid_reg, rvalid_next;
    logic                       last_reg, last_next;
    logic                       done_reg, done_next;

    // Payload state
    logic [1:0]                 kind_reg, kind_next;
    logic [KEY_WIDTH-1:0]       key_reg, key_next;
    logic [POSW-1:0]            pos_reg, pos_next;
    logic                       found_reg, found_next;
    logic [POSW-1:0]            fstart_reg, fstart_next;
    fts_pkg::result_t           result_reg, result_next;

    // RAM ports
    logic                       tbl_we;
    logic [TAW-1:0]             tbl_raddr;
    logic [TW-1:0]              tbl_wdata, tbl_rdata;
    logic                       stk_we;
    logic [SAW-1:0]             stk_raddr;
    logic [POSW-1:0]            stk_rdata;

    logic                       accept;
    logic                       issue;
    logic                       idx_is_last;
    logic                       hit;

    // Function table: key in the upper bits, start position below.
    fts_ram #(
        .WIDTH (TW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (fill_reg[TAW-1:0]),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Return stack of saved positions.
    fts_ram #(
        .WIDTH (POSW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (active_reg[SAW-1:0]),
        .wdata (pos_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign tbl_wdata   = {key_reg, pos_reg + POSW'(1)};
    assign stk_raddr   = active_reg[SAW-1:0] - SAW'(1);
    assign idx_is_last = (FW'(idx_reg) == fill_reg - FW'(1));
    assign hit         = (tbl_rdata[TW-1:POSW] == key_reg);

    // Sequencer. Writes happen only in the decision cycle and the next read
    // is issued only after the unit has passed through idle, so the RAMs never
    // see a read and a write of the same entry overlap.
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        active_next     = active_reg;
        idx_next        = idx_reg;
        issued_all_next = issued_all_reg;
        rvalid_next     = 1'b0;
        last_next       = 1'b0;
        done_next       = 1'b0;
        kind_next       = kind_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        fstart_next     = fstart_reg;
        result_next     = result_reg;
        tbl_we          = 1'b0;
        stk_we          = 1'b0;
        tbl_raddr       = idx_reg;
        issue           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = cmd.kind;
                    key_next        = cmd.func_id[KEY_WIDTH-1:0];
                    pos_next        = cmd.code_position;
                    idx_next        = '0;
                    issued_all_next = 1'b0;
                    found_next      = 1'b0;
                    result_next.new_position = cmd.code_position;
                    result_next.status       = fts_pkg::ST_OK;
                    result_next.call_depth   = DW'(active_next);
                    case (cmd.kind) inside
                        fts_pkg::KIND_DEFINE, fts_pkg::KIND_CALL:
                        begin
                            if (fill_reg == '0)
                            begin
                                state_next = S_DECIDE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        fts_pkg::KIND_RETURN:
                        begin
                            if (active_reg == '0)
                            begin
                                result_next.status = fts_pkg::ST_EMPTY;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one read a cycle and compare the entry read the cycle before.
                issue = !issued_all_reg;
                if (issue)
                begin
                    idx_next        = idx_reg + TAW'(1);
                    issued_all_next = idx_is_last;
                    rvalid_next     = 1'b1;
                    last_next       = idx_is_last;
                end
                if (rvalid_reg && hit)
                begin
                    found_next  = 1'b1;
                    fstart_next = tbl_rdata[POSW-1:0];
                    state_next  = S_DECIDE;
                end
                else if (rvalid_reg && last_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                result_next.new_position = pos_reg;
                result_next.status       = fts_pkg::ST_OK;
                if (kind_reg == fts_pkg::KIND_DEFINE)
                begin
                    if (found_reg)
                    begin
                        result_next.status = fts_pkg::ST_EXISTS;
                    end
                    else if (32'(active_reg) > 32'(limit_reg))
                    begin
                        result_next.status = fts_pkg::ST_DEPTH;
                    end
                    else if (32'(fill_reg) == 32'(TABLE_DEPTH))
                    begin
                        result_next.status = fts_pkg::ST_TFULL;
                    end
                    else
                    begin
                        tbl_we    = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                end
                else
                begin
                    if (!found_reg)
                    begin
                        result_next.status = fts_pkg::ST_UNDEF;
                    end
                    else if (32'(active_reg) == 32'(STACK_DEPTH))
                    begin
                        result_next.status = fts_pkg::ST_DEPTH;
                    end
                    else
                    begin
                        stk_we                   = 1'b1;
                        active_next              = active_reg + AC'(1);
                        result_next.new_position = fstart_reg;
                    end
                end
                result_next.call_depth = DW'(active_next);
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end

            S_POP:
            begin
                // Stack read was issued in the transfer cycle.
                active_next              = active_reg - AC'(1);
                result_next.new_position = stk_rdata;
                result_next.status       = fts_pkg::ST_OK;
                result_next.call_depth   = DW'(active_next);
                done_next                = 1'b1;
                state_next               = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            active_reg     <= '0;
            limit_reg      <= fts_pkg::DEPTH_LIMIT_RESET;
            idx_reg        <= '0;
            issued_all_reg <= 1'b0;
            rvalid_reg     <= 1'b0;
            last_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            issued_all_reg <= issued_all_next;
            rvalid_reg     <= rvalid_next;
            last_reg       <= last_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        fstart_reg <= fstart_next;
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    // A result strobe only follows a transfer or a command under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept || busy))
        else $error("result strobe without a command");

    // A transfer either finishes at once or keeps the unit busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("command transfer lost");

    // The table is never written beyond its last entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (32'(fill_reg) < 32'(TABLE_DEPTH)) && (state_reg == S_DECIDE))
        else $error("table write past its end");

    // A stack push never goes beyond the stack's depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> (32'(active_reg) < 32'(STACK_DEPTH)) && found_reg)
        else $error("stack push past its end");
`endif

endmodule

// File: tb/function_table_call_stack_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Function table call stack unit testbench
// Drives define, call, return and unused commands in random bursts, writes
// the depth limit between phases and checks every result transfer against
// a scoreboard that keeps its own copy of the table and the return stack.
// ---------------------------------------------------------------------------
module function_table_call_stack_unit_tb;

    localparam int TABLE_N    = fts_pkg::TABLE_DEPTH_DEFAULT;
    localparam int STACK_N    = fts_pkg::STACK_DEPTH_DEFAULT;
    localparam int PW         = fts_pkg::POS_W;
    localparam int POOL_N     = 40;
    localparam int PHASE_LEN  = 220;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [fts_pkg::POS_W-1:0] POS_MAX = '1;
    localparam logic [fts_pkg::ID_W-1:0]  ID_MAX  = '1;

    // Scoreboard: predicts each result from its own table and stack copy.
    class call_stack_scoreboard;
        logic [fts_pkg::DEPTH_W-1:0] depth_limit;
        bit                          slot_used[TABLE_N];
        logic [fts_pkg::ID_W-1:0]    slot_id[TABLE_N];
        logic [fts_pkg::POS_W-1:0]   slot_start[TABLE_N];
        logic [fts_pkg::POS_W-1:0]   return_pos[STACK_N];
        int unsigned                 active_calls;
        fts_pkg::result_t            expected_results[$];
        int unsigned                 mismatches;

        function new();
            depth_limit = fts_pkg::DEPTH_LIMIT_RESET;
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            active_calls = 0;
            mismatches = 0;
        endfunction

        function int find_slot(logic [fts_pkg::ID_W-1:0] id);
            foreach (slot_used[i])
                if (slot_used[i] && slot_id[i] == id)
                    return i;
            return -1;
        endfunction

        function void write_limit(logic [fts_pkg::DEPTH_W-1:0] value);
            depth_limit = value;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        // Works out the result of one accepted command and queues it.
        function void note_command(fts_pkg::cmd_t c);
            fts_pkg::result_t r;
            int               hit;
            int               free_slot;
            r.new_position = c.code_position;
            r.status = fts_pkg::ST_OK;
            hit = find_slot(c.func_id);
            free_slot = -1;
            case (c.kind)
                fts_pkg::KIND_DEFINE:
                begin
                    if (hit >= 0)
                        r.status = fts_pkg::ST_EXISTS;
                    else if (active_calls > depth_limit)
                        r.status = fts_pkg::ST_DEPTH;
                    else
                    begin
                        foreach (slot_used[i])
                            if (!slot_used[i] && free_slot < 0)
                                free_slot = i;
                        if (free_slot < 0)
                            r.status = fts_pkg::ST_TFULL;
                        else
                        begin
                            slot_used[free_slot] = 1'b1;
                            slot_id[free_slot] = c.func_id;
                            slot_start[free_slot] = c.code_position + 1'b1;
                        end
                    end
                end
                fts_pkg::KIND_CALL:
                begin
                    if (hit < 0)
                        r.status = fts_pkg::ST_UNDEF;
                    else if (active_calls >= STACK_N)
                        r.status = fts_pkg::ST_DEPTH;
                    else
                    begin
                        return_pos[active_calls] = c.code_position;
                        active_calls++;
                        r.new_position = slot_start[hit];
                    end
                end
                fts_pkg::KIND_RETURN:
                begin
                    if (active_calls == 0)
                        r.status = fts_pkg::ST_EMPTY;
                    else
                    begin
                        active_calls--;
                        r.new_position = return_pos[active_calls];
                    end
                end
                default:
                begin
                    // The unused kind leaves everything as it is.
                end
            endcase
            r.call_depth = active_calls[fts_pkg::DEPTH_W-1:0];
            expected_results.push_back(r);
        endfunction

        // Compares one result transfer with the oldest prediction.
        function void check_result(fts_pkg::result_t got);
            fts_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("unexpected result pos %h status %0d depth %0d",
                                 got.new_position, got.status, got.call_depth));
                return;
            end
            want = expected_results.pop_front();
            if (got.new_position !== want.new_position || got.status !== want.status ||
                got.call_depth !== want.call_depth)
                report($sformatf({"expected pos %h status %0d depth %0d, ",
                                  "got pos %h status %0d depth %0d"},
                                 want.new_position, want.status, want.call_depth,
                                 got.new_position, got.status, got.call_depth));
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    fts_pkg::cmd_t               cmd = '0;
    logic                        done;
    fts_pkg::result_t            result;
    logic                        cfg_we = 1'b0;
    logic [fts_pkg::DEPTH_W-1:0] cfg_data = '0;

    call_stack_scoreboard        sb = new();
    logic [fts_pkg::ID_W-1:0]    id_pool[POOL_N];
    int                          burst_left = 0;
    int unsigned                 idle_cycles = 0;

    function_table_call_stack_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor of both sides and the configuration port, with the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_limit(cfg_data);
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_command(cmd);
            if (cfg_we || done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offers one command and returns at the edge of its transfer. Commands go
    // out in bursts; a gap of random length comes between bursts.
    task automatic send_cmd(input fts_pkg::kind_t k, input logic [fts_pkg::ID_W-1:0] id,
                            input logic [fts_pkg::POS_W-1:0] pos);
        fts_pkg::cmd_t c;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        c.kind = k;
        c.func_id = id;
        c.code_position = pos;
        cmd <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Holds commands back until every predicted result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (sb.expected_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_depth_limit(input logic [fts_pkg::DEPTH_W-1:0] value);
        drain_results();
        repeat (2) @(posedge clk);
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Picks an identifier that is already in the table, if there is one.
    function automatic logic [fts_pkg::ID_W-1:0] pick_defined_id();
        int used[$];
        foreach (sb.slot_used[i])
            if (sb.slot_used[i])
                used.push_back(i);
        if (used.size() == 0)
            return id_pool[$urandom_range(0, POOL_N - 1)];
        return sb.slot_id[used[$urandom_range(0, used.size() - 1)]];
    endfunction

    // Random commands with a mix of kinds chosen afresh for each phase.
    task automatic run_random_phase(input int items);
        int                        def_pct;
        int                        call_pct;
        int                        roll;
        fts_pkg::kind_t            k;
        logic [fts_pkg::ID_W-1:0]  id;
        logic [fts_pkg::POS_W-1:0] pos;
        def_pct = $urandom_range(10, 35);
        call_pct = $urandom_range(25, 50);
        repeat (items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < def_pct)
                k = fts_pkg::KIND_DEFINE;
            else if (roll < def_pct + call_pct)
                k = fts_pkg::KIND_CALL;
            else if (roll < 95)
                k = fts_pkg::KIND_RETURN;
            else
                k = fts_pkg::KIND_NONE;
            roll = $urandom_range(0, 99);
            if (roll < 50 && k == fts_pkg::KIND_CALL)
                id = pick_defined_id();
            else if (roll < 85)
                id = id_pool[$urandom_range(0, POOL_N - 1)];
            else
                id = $urandom;
            if ($urandom_range(0, 9) == 0)
                pos = $urandom_range(0, 1) ? POS_MAX : '0;
            else
                pos = PW'($urandom_range(0, POS_MAX));
            send_cmd(k, id, pos);
        end
    endtask

    // Fills the return stack past its end, tries defines at full depth and
    // then unwinds past the bottom.
    task automatic dive_to_full_stack();
        repeat (STACK_N + 2)
            send_cmd(fts_pkg::KIND_CALL, pick_defined_id(),
                     PW'($urandom_range(0, POS_MAX)));
        repeat (3)
            send_cmd(fts_pkg::KIND_DEFINE, $urandom, PW'($urandom_range(0, POS_MAX)));
        repeat (STACK_N + 4)
            send_cmd(fts_pkg::KIND_RETURN, $urandom, PW'($urandom_range(0, POS_MAX)));
    endtask

    // Stimulus sequence.
    initial
    begin
        logic [fts_pkg::DEPTH_W-1:0] phase_limits[6];
        id_pool[0] = '0;
        id_pool[1] = ID_MAX;
        for (int i = 2; i < POOL_N; i++)
            id_pool[i] = $urandom;
        phase_limits[0] = 7'd0;
        phase_limits[1] = 7'd63;
        phase_limits[2] = 7'd64;
        phase_limits[3] = 7'($urandom_range(0, 64));
        phase_limits[4] = 7'd1;
        phase_limits[5] = 7'($urandom_range(0, 64));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands: empty stack, unknown id, redefinition, start
        // position wrapping, the unused kind and the depth check order.
        send_cmd(fts_pkg::KIND_RETURN, '0, '0);
        send_cmd(fts_pkg::KIND_CALL, '0, POS_MAX);
        send_cmd(fts_pkg::KIND_DEFINE, '0, '0);
        send_cmd(fts_pkg::KIND_DEFINE, ID_MAX, POS_MAX);
        send_cmd(fts_pkg::KIND_DEFINE, '0, 24'd5);
        send_cmd(fts_pkg::KIND_NONE, ID_MAX, POS_MAX);
        send_cmd(fts_pkg::KIND_CALL, ID_MAX, 24'h123456);
        send_cmd(fts_pkg::KIND_CALL, '0, 24'hAAAAAA);
        write_depth_limit(7'd0);
        send_cmd(fts_pkg::KIND_DEFINE, 32'h5555_5555, 24'h555555);
        send_cmd(fts_pkg::KIND_DEFINE, '0, 24'h555555);
        write_depth_limit(7'd2);
        send_cmd(fts_pkg::KIND_DEFINE, 32'hAAAA_AAAA, 24'h555555);
        send_cmd(fts_pkg::KIND_RETURN, '0, '0);
        send_cmd(fts_pkg::KIND_RETURN, ID_MAX, POS_MAX);
        send_cmd(fts_pkg::KIND_RETURN, '0, '0);
        send_cmd(fts_pkg::KIND_NONE, '0, '0);
        send_cmd(fts_pkg::KIND_CALL, 32'hAAAA_AAAA, '0);
        send_cmd(fts_pkg::KIND_RETURN, '0, 24'h0F0F0F);
        write_depth_limit(fts_pkg::DEPTH_LIMIT_RESET);

        // Random phases, each under its own depth limit.
        run_random_phase(PHASE_LEN);
        foreach (phase_limits[p])
        begin
            write_depth_limit(phase_limits[p]);
            run_random_phase(PHASE_LEN);
            if (p == 1 || p == 2)
                dive_to_full_stack();
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
